>>> rtl/core/nibble_stack_machine_core_top_assert.svh
// Assertion macros for the nibble stack machine core.
// Used by nibble_stack_machine_core_top; no other dependencies.
`ifndef NIBBLE_STACK_MACHINE_CORE_TOP_ASSERT_SVH
`define NIBBLE_STACK_MACHINE_CORE_TOP_ASSERT_SVH
// Implication checked on the rising edge, quiet while in reset.
`define NSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Same, with the consequence checked in the cycle after the antecedent.
`define NSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/nsm_pkg.sv
// Package for the nibble stack machine core: constants, opcodes, status and state types.
// No dependencies.
package nsm_pkg;
    localparam int unsigned STACK_DEPTH = 1024;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = AW + 1;

    typedef enum logic [3:0] {
        OP_LIT = 4'd0, OP_AND = 4'd1, OP_NOT = 4'd2, OP_OR = 4'd3,
        OP_MUL = 4'd4, OP_DIV = 4'd5, OP_ADD = 4'd6, OP_EQ = 4'd7,
        OP_POP = 4'd8, OP_SWAP = 4'd9, OP_DUP = 4'd10, OP_PPC = 4'd11,
        OP_RD = 4'd12, OP_WR = 4'd13, OP_BR = 4'd14, OP_UND = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_UNDEF = 3'd3,
        ST_EOF = 3'd4, ST_DIVZ = 3'd5, ST_HALT = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_POPA, S_POPB, S_EXEC, S_DIV, S_SWRD, S_SWWR, S_SWAP0, S_DONE
    } t_state;
endpackage

>>> rtl/core/nibble_stack_machine_core_top.sv
// Nibble stack machine core: one instruction nibble per input transaction.
// Each item runs through decode (unless halted) and, as needed, pops and execute; signed
// divide adds a divide state; each chained swap-zero re-enters decode. One transaction in
// flight; the next is taken once the result register is empty or being taken. Stack
// memory is a synchronous-read RAM, not cleared. Synchronous active-low reset clears
// control state. Depends on nsm_pkg and nibble_stack_machine_core_top_assert.svh.
`include "nibble_stack_machine_core_top_assert.svh"
module nibble_stack_machine_core_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_code,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_valid,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_in_taken,
    output logic [2:0]  o_status
);
    import nsm_pkg::*;

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    t_state      r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0] r_pc, n_pc;
    logic        r_lit, n_lit;
    logic        r_halt, n_halt;
    logic [3:0]  r_op, n_op;
    logic [7:0]  r_ib, n_ib;
    logic        r_iv, n_iv;
    logic [31:0] r_a, n_a, r_b, n_b;
    logic        r_ovld, n_ovld;
    logic [31:0] r_opc, n_opc;
    logic [7:0]  r_ob, n_ob;
    logic        r_oov, n_oov, r_otk, n_otk;
    logic [2:0]  r_ost, n_ost;
    // divider
    logic [31:0] r_q, n_q, r_rem, n_rem, r_dv, n_dv;
    logic [5:0]  r_dc, n_dc;
    logic        r_neg, n_neg;
    logic [32:0] dsub;

    assign o_stall  = (r_state != S_IDLE) || (r_ovld && i_stall);
    assign o_valid  = r_ovld;
    assign o_next_pc = r_opc;
    assign o_out_byte = r_ob;
    assign o_out_valid = r_oov;
    assign o_in_taken = r_otk;
    assign o_status = r_ost;

    logic [CW-1:0] depth_c;
    assign depth_c = CW'(STACK_DEPTH);
    assign dsub = {r_rem[30:0], r_q[31]} - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pc <= '0;
            r_lit <= 1'b0;
            r_halt <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pc <= n_pc;
            r_lit <= n_lit;
            r_halt <= n_halt;
            r_ovld <= n_ovld;
        end
        r_op <= n_op; r_ib <= n_ib; r_iv <= n_iv; r_a <= n_a; r_b <= n_b;
        r_opc <= n_opc; r_ob <= n_ob; r_oov <= n_oov; r_otk <= n_otk; r_ost <= n_ost;
        r_q <= n_q; r_rem <= n_rem; r_dv <= n_dv; r_dc <= n_dc; r_neg <= n_neg;
    end

    always_comb begin
        logic [31:0] res;
        logic        push;
        logic        fin;
        t_status     f;
        n_state = r_state; n_cnt = r_cnt; n_pc = r_pc; n_lit = r_lit; n_halt = r_halt;
        n_op = r_op; n_ib = r_ib; n_iv = r_iv; n_a = r_a; n_b = r_b;
        n_ovld = r_ovld && i_stall;
        n_opc = r_opc; n_ob = r_ob; n_oov = r_oov; n_otk = r_otk; n_ost = r_ost;
        n_q = r_q; n_rem = r_rem; n_dv = r_dv; n_dc = r_dc; n_neg = r_neg;
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
        mem_raddr = AW'(r_cnt - CW'(1));
        res = '0; push = 1'b0; fin = 1'b0; f = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_op = i_code; n_ib = i_in_byte; n_iv = i_in_valid;
                    if (r_halt) begin
                        n_ovld = 1'b1; n_opc = r_pc; n_ob = '0; n_oov = 1'b0;
                        n_otk = 1'b0; n_ost = ST_HALT;
                    end else begin
                        n_pc = r_pc + 32'd1;
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                // mem read of top is already in flight (raddr = cnt-1)
                if (r_lit) begin
                    n_lit = 1'b0; res = {28'd0, r_op}; push = 1'b1; fin = 1'b1;
                end else begin
                    unique case (t_op'(r_op))
                        OP_LIT: begin n_lit = 1'b1; fin = 1'b1; end
                        OP_DUP: begin
                            if (r_cnt == '0) begin f = ST_UNDER; fin = 1'b1; end
                            else n_state = S_POPA;
                        end
                        OP_PPC: begin res = r_pc; push = 1'b1; fin = 1'b1; end
                        OP_RD: begin
                            if (!r_iv) begin f = ST_EOF; fin = 1'b1; end
                            else begin res = {24'd0, r_ib}; push = 1'b1; fin = 1'b1; end
                        end
                        OP_UND: begin f = ST_UNDEF; fin = 1'b1; end
                        default: begin
                            if (r_cnt == '0 || r_cnt > depth_c) begin
                                f = ST_UNDER; fin = 1'b1;
                            end else begin
                                n_cnt = r_cnt - CW'(1);
                                n_state = S_POPA;
                            end
                        end
                    endcase
                end
            end
            S_POPA: begin
                // r_rdata = top; second read addr = cnt-1 (cnt already decremented)
                n_a = r_rdata;
                unique case (t_op'(r_op))
                    OP_NOT: begin res = ~r_rdata; push = 1'b1; fin = 1'b1; end
                    OP_POP: fin = 1'b1;
                    OP_DUP: begin res = r_rdata; push = 1'b1; fin = 1'b1; end
                    OP_WR: begin n_oov = 1'b1; n_ob = r_rdata[7:0]; fin = 1'b1; end
                    OP_SWAP: begin
                        if (r_cnt == '0) begin f = ST_UNDER; fin = 1'b1; end
                        else if (r_rdata == '0) begin
                            n_cnt = r_cnt - CW'(1); n_state = S_SWAP0;
                        end else if (r_rdata >= 32'(r_cnt)) begin
                            f = ST_UNDER; fin = 1'b1;
                        end else begin
                            mem_raddr = AW'(r_cnt - CW'(1) - CW'(r_rdata));
                            n_state = S_SWRD;
                        end
                    end
                    default: begin
                        if (r_cnt == '0) begin f = ST_UNDER; fin = 1'b1; end
                        else begin n_cnt = r_cnt - CW'(1); n_state = S_POPB; end
                    end
                endcase
            end
            S_POPB: begin
                n_b = r_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (t_op'(r_op))
                    OP_AND: begin res = r_a & r_b; push = 1'b1; fin = 1'b1; end
                    OP_OR:  begin res = r_a | r_b; push = 1'b1; fin = 1'b1; end
                    OP_MUL: begin res = r_a * r_b; push = 1'b1; fin = 1'b1; end
                    OP_ADD: begin res = r_a + r_b; push = 1'b1; fin = 1'b1; end
                    OP_EQ:  begin res = {31'd0, r_a == r_b}; push = 1'b1; fin = 1'b1; end
                    OP_BR: begin
                        if (r_a != '0) n_pc = r_b;
                        fin = 1'b1;
                    end
                    OP_DIV: begin
                        if (r_b == '0) begin f = ST_DIVZ; fin = 1'b1; end
                        else begin
                            n_q = r_a[31] ? -r_a : r_a;
                            n_dv = r_b[31] ? -r_b : r_b;
                            n_rem = '0; n_dc = '0;
                            n_neg = r_a[31] ^ r_b[31];
                            n_state = S_DIV;
                        end
                    end
                    default: fin = 1'b1;
                endcase
            end
            S_DIV: begin
                if (r_dc == 6'd32) begin
                    res = r_neg ? -r_q : r_q; push = 1'b1; fin = 1'b1;
                end else begin
                    n_dc = r_dc + 6'd1;
                    if (!dsub[32]) begin
                        n_rem = dsub[31:0]; n_q = {r_q[30:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[30:0], r_q[31]}; n_q = {r_q[30:0], 1'b0};
                    end
                end
            end
            S_SWRD: begin
                // r_a holds param; top at cnt-1; r_rdata = deep entry
                n_b = r_rdata;
                mem_raddr = AW'(r_cnt - CW'(1));
                n_state = S_SWWR;
            end
            S_SWWR: begin
                // r_rdata = top; write deep <- top, then top <- deep
                mem_we = 1'b1;
                mem_waddr = AW'(r_cnt - CW'(1) - CW'(r_a));
                mem_wdata = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                mem_we = 1'b1;
                mem_waddr = AW'(r_cnt - CW'(1));
                mem_wdata = r_b;
                fin = 1'b1;
            end
            S_SWAP0: begin
                // r_rdata = popped value; execute its low nibble
                n_op = r_rdata[3:0];
                n_state = S_DECODE;
            end
            default: n_state = S_IDLE;
        endcase
        if (push) begin
            if (n_cnt >= depth_c) f = ST_OVER;
            else begin
                mem_we = 1'b1; mem_waddr = AW'(n_cnt); mem_wdata = res;
                n_cnt = n_cnt + CW'(1);
                if (t_op'(r_op) == OP_RD && !r_lit) n_otk = 1'b1;
            end
        end
        if (fin) begin
            n_state = S_IDLE;
            n_ovld = 1'b1;
            n_opc = n_pc;
            n_ost = f;
            if (f != ST_OK) begin
                n_halt = 1'b1; n_oov = 1'b0; n_otk = 1'b0; n_ob = '0;
            end else begin
                if (!n_oov) n_ob = '0;
            end
        end
        if (r_state == S_IDLE && n_state == S_DECODE) begin
            n_oov = 1'b0; n_otk = 1'b0; n_ob = '0;
            mem_raddr = AW'(r_cnt - CW'(1));
        end
    end

    `NSM_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= depth_c, "stack count over depth")
    `NSM_ASSERT_IMP(a_halt_stat, i_clk, i_rst_n, r_ovld && r_ost != ST_OK, r_halt,
        "fault without halt")
    `NSM_ASSERT_IMP(a_fault_quiet, i_clk, i_rst_n, r_ovld && r_ost != ST_OK,
        !r_oov && !r_otk, "fault with side output")
    `NSM_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt, "halt cleared")
endmodule

>>> tb/tb.sv
// Testbench for nibble_stack_machine_core_top: directed table plus random instruction streams.
// Results are checked against a predictor or typed table rows. Depends on nsm_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
    import nsm_pkg::*;

    typedef struct packed {
        logic [31:0] pc;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        in_taken;
        t_status     status;
    } t_result;

    typedef struct {
        logic [3:0] code;
        logic [7:0] in_byte;
        logic       in_valid;
        logic       typed;
        t_result    res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_code = '0;
    logic [7:0]  i_in_byte = '0;
    logic        i_in_valid = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_next_pc;
    logic [7:0]  o_out_byte;
    logic        o_out_valid;
    logic        o_in_taken;
    logic [2:0]  o_status;

    nibble_stack_machine_core_top i_dut (.*);

    // machine state as predicted
    logic [31:0] stk [0:STACK_DEPTH-1];
    int          depth;
    logic [31:0] pc;
    logic        lit_pend;
    logic        stopped;
    t_status     fault;

    t_result     pending_results[$];
    int          errors = 0;
    int          n_sent = 0;
    int          n_recv = 0;
    int          n_writes = 0;
    int          n_reads = 0;
    int          idle_cycles = 0;
    bit          sent_all = 1'b0;
    int          fatal_kind;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit pop_word(output logic [31:0] v);
        v = '0;
        if (depth == 0) begin
            fault = ST_UNDER;
            return 1'b0;
        end
        depth--;
        v = stk[depth];
        return 1'b1;
    endfunction

    function automatic bit push_word(logic [31:0] v);
        if (depth >= STACK_DEPTH) begin
            fault = ST_OVER;
            return 1'b0;
        end
        stk[depth] = v;
        depth++;
        return 1'b1;
    endfunction

    function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    function automatic t_result execute(logic [3:0] code, logic [7:0] ib, logic iv);
        t_result r;
        logic [3:0] op;
        logic [31:0] a, b;
        bit again;
        r = '{pc: pc, out_byte: '0, out_valid: 1'b0, in_taken: 1'b0, status: ST_HALT};
        if (stopped) return r;
        fault = ST_OK;
        pc++;
        op = code;
        do begin
            again = 1'b0;
            if (lit_pend) begin
                lit_pend = 1'b0;
                void'(push_word({28'd0, op}));
                break;
            end
            case (t_op'(op))
                OP_LIT: lit_pend = 1'b1;
                OP_AND: if (pop_word(a) && pop_word(b)) void'(push_word(a & b));
                OP_NOT: if (pop_word(a)) void'(push_word(~a));
                OP_OR:  if (pop_word(a) && pop_word(b)) void'(push_word(a | b));
                OP_MUL: if (pop_word(a) && pop_word(b)) void'(push_word(a * b));
                OP_DIV: if (pop_word(a) && pop_word(b)) begin
                    if (b == 0) fault = ST_DIVZ;
                    else void'(push_word(quot32(a, b)));
                end
                OP_ADD: if (pop_word(a) && pop_word(b)) void'(push_word(a + b));
                OP_EQ:  if (pop_word(a) && pop_word(b)) void'(push_word({31'd0, a == b}));
                OP_POP: void'(pop_word(a));
                OP_SWAP: if (pop_word(a)) begin
                    if (depth == 0) fault = ST_UNDER;
                    else if (a != 0) begin
                        if (a >= depth) fault = ST_UNDER;
                        else begin
                            b = stk[depth-1];
                            stk[depth-1] = stk[depth-1-a];
                            stk[depth-1-a] = b;
                        end
                    end else begin
                        void'(pop_word(b));
                        op = b[3:0];
                        again = 1'b1;
                    end
                end
                OP_DUP: if (depth == 0) fault = ST_UNDER;
                        else void'(push_word(stk[depth-1]));
                OP_PPC: void'(push_word(pc));
                OP_RD: if (!iv) fault = ST_EOF;
                       else if (push_word({24'd0, ib})) r.in_taken = 1'b1;
                OP_WR: if (pop_word(a)) begin
                    r.out_byte = a[7:0];
                    r.out_valid = 1'b1;
                end
                OP_BR: if (pop_word(a) && pop_word(b)) begin
                    if (a != 0) pc = b;
                end
                default: fault = ST_UNDEF;
            endcase
        end while (again && fault == ST_OK);
        if (fault != ST_OK) begin
            stopped = 1'b1;
            r.out_byte = '0;
            r.out_valid = 1'b0;
            r.in_taken = 1'b0;
        end
        r.pc = pc;
        r.status = fault;
        return r;
    endfunction

    // trial run on a copy; true if the item keeps the machine running
    function automatic bit is_safe(logic [3:0] code, logic [7:0] ib, logic iv);
        logic [31:0] stk_s [0:STACK_DEPTH-1];
        int d_s;
        logic [31:0] pc_s;
        logic lp_s;
        t_result r;
        stk_s = stk;
        d_s = depth;
        pc_s = pc;
        lp_s = lit_pend;
        r = execute(code, ib, iv);
        stk = stk_s;
        depth = d_s;
        pc = pc_s;
        lit_pend = lp_s;
        stopped = 1'b0;
        return r.status == ST_OK;
    endfunction

    task automatic send(logic [3:0] code, logic [7:0] ib, logic iv, logic typed, t_result tr);
        t_result r;
        int gap;
        i_valid <= 1'b1;
        i_code <= code;
        i_in_byte <= ib;
        i_in_valid <= iv;
        do @(posedge i_clk); while (o_stall);
        r = execute(code, ib, iv);
        pending_results.push_back(typed ? tr : r);
        n_sent++;
        if (r.out_valid) n_writes++;
        if (r.in_taken) n_reads++;
        gap = ($urandom_range(0, 3) == 0) ?
              (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3)) : 0;
        if (n_sent % 300 > 200) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [3:0] pick_fatal();
        if (lit_pend) return 4'(OP_LIT);
        case (fatal_kind)
            0: return 4'(OP_POP);
            1: return (depth == 0) ? 4'(OP_PPC) : 4'(OP_DUP);
            2: return 4'(OP_UND);
            3: return 4'(OP_RD);
            default: begin
                if (depth == 0) return 4'(OP_LIT);
                if (depth == 1 && stk[0] == 0) return 4'(OP_PPC);
                if (depth >= 2 && stk[depth-2] == 0) return 4'(OP_DIV);
                return 4'(OP_POP);
            end
        endcase
    endfunction

    t_row dir_rows[$];

    function automatic t_row row(logic [3:0] c, logic [7:0] ib = 8'h00, logic iv = 1'b1);
        t_row x;
        x.code = c;
        x.in_byte = ib;
        x.in_valid = iv;
        x.typed = 1'b0;
        x.res = '0;
        return x;
    endfunction

    function automatic t_row trow(logic [3:0] c, logic [7:0] ib, logic iv, logic [31:0] epc,
                                  logic [7:0] eob, logic eov, logic etk);
        t_row x;
        x = row(c, ib, iv);
        x.typed = 1'b1;
        x.res = '{pc: epc, out_byte: eob, out_valid: eov, in_taken: etk, status: ST_OK};
        return x;
    endfunction

    // sender
    initial begin
        logic [3:0] c;
        logic [7:0] ib;
        logic iv;
        int tries;
        int n_rand;
        depth = 0;
        pc = '0;
        lit_pend = 1'b0;
        stopped = 1'b0;
        fault = ST_OK;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            trow(OP_LIT, 8'h00, 1'b0, 1, 0, 0, 0), trow(4'hF, 8'hFF, 1'b1, 2, 0, 0, 0),
            trow(OP_LIT, 8'hAA, 1'b1, 3, 0, 0, 0), trow(OP_LIT, 8'h55, 1'b0, 4, 0, 0, 0),
            trow(OP_NOT, 8'h00, 1'b1, 5, 0, 0, 0), trow(OP_RD, 8'hFF, 1'b1, 6, 0, 0, 1),
            trow(OP_WR, 8'h00, 1'b1, 7, 8'hFF, 1, 0), trow(OP_ADD, 8'h00, 1'b0, 8, 0, 0, 0),
            row(OP_LIT), row(4'd3), row(OP_DIV), row(OP_DUP), row(OP_EQ), row(OP_PPC),
            row(OP_OR), row(OP_LIT), row(4'd9), row(OP_AND), row(OP_DUP), row(OP_MUL),
            row(OP_PPC), row(OP_LIT), row(4'd1), row(OP_SWAP), row(OP_LIT), row(4'd1),
            row(OP_BR), row(OP_LIT), row(OP_DUP), row(OP_LIT), row(4'd0), row(OP_SWAP),
            row(OP_POP), row(OP_RD, 8'h00, 1'b1), row(OP_WR, 8'h00, 1'b0)
        };
        foreach (dir_rows[k])
            send(dir_rows[k].code, dir_rows[k].in_byte, dir_rows[k].in_valid,
                 dir_rows[k].typed, dir_rows[k].res);

        // the overflow ending fills the whole stack, so it gets a shorter random part
        fatal_kind = $urandom_range(0, 4);
        n_rand = (fatal_kind == 1) ? 1200 - int'(STACK_DEPTH) : 1200;
        for (int n = 0; n < n_rand; n++) begin
            if (n == n_rand / 2) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            tries = 0;
            do begin
                ib = 8'($urandom);
                iv = ($urandom_range(0, 7) != 0);
                if (lit_pend) c = 4'($urandom);
                else if ($urandom_range(0, 2) == 0) c = 4'(OP_LIT);
                else if (depth > 40 && $urandom_range(0, 1) == 0) c = 4'(OP_POP);
                else c = 4'($urandom);
                tries++;
            end while (!is_safe(c, ib, iv) && tries < 40);
            if (tries >= 40) begin
                c = 4'(OP_LIT);
            end
            send(c, ib, iv, 1'b0, '0);
        end

        // one fatal condition per run, then a few items on the halted machine
        while (!stopped) send(pick_fatal(), 8'($urandom), fatal_kind == 3 ? 1'b0 : 1'b1, 0, '0);
        repeat (4) send(4'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
        i_valid <= 1'b0;
        sent_all = 1'b1;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int hold;
        bit held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && n_recv >= 300) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end
            if ((n_recv % 250) > 180 || $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_recv++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, pc %h status %0d",
                         $time, o_next_pc, o_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_next_pc !== want.pc) begin
                    $display("%0t: next_pc expected %h actual %h", $time, want.pc, o_next_pc);
                    errors++;
                end
                if (o_out_byte !== want.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, o_out_byte);
                    errors++;
                end
                if (o_out_valid !== want.out_valid) begin
                    $display("%0t: out_valid expected %b actual %b",
                             $time, want.out_valid, o_out_valid);
                    errors++;
                end
                if (o_in_taken !== want.in_taken) begin
                    $display("%0t: in_taken expected %b actual %b",
                             $time, want.in_taken, o_in_taken);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        wait (sent_all);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("tb: %0d instructions, %0d results, %0d writes, %0d reads, fatal kind %0d",
                 n_sent, n_recv, n_writes, n_reads, fatal_kind);
        $display("tb: covered all opcodes, swap chains, branches and a final halt");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
